// ===== rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

    // Number of scanned positions and the index of the last one
    localparam int unsigned POS_NUM      = 5;
    localparam logic [2:0]  POS_LAST     = 3'd4;
    localparam logic [2:0]  POS_FIRST    = 3'd0;

    // Reset value of the copy period register
    localparam logic [15:0] PERIOD_RESET = 16'd240;

    // Fixed patterns of the fifth position
    localparam logic [7:0]  SEG_POS4_ON  = 8'hfc;
    localparam logic [7:0]  SEG_BLANK    = 8'hff;
    localparam logic [7:0]  POS4_ON_CODE = 8'h01;

    // Beat kinds carried in tuser
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Input stage to core
    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [2:0] idx;
        logic [7:0] code;
    } in_beat_t;

    // Font of 29 glyphs, active low; indices beyond the font are blank
    function automatic logic [7:0] glyph_lookup(input logic [4:0] g);
        logic [7:0] seg;
        case (g)
            5'd0:    seg = 8'hc0;
            5'd1:    seg = 8'hf9;
            5'd2:    seg = 8'ha4;
            5'd3:    seg = 8'hb0;
            5'd4:    seg = 8'h99;
            5'd5:    seg = 8'h92;
            5'd6:    seg = 8'h82;
            5'd7:    seg = 8'hf8;
            5'd8:    seg = 8'h80;
            5'd9:    seg = 8'h90;
            5'd10:   seg = 8'hbf;
            5'd11:   seg = 8'hff;
            5'd12:   seg = 8'h86;
            5'd13:   seg = 8'h88;
            5'd14:   seg = 8'hc7;
            5'd15:   seg = 8'ha3;
            5'd16:   seg = 8'h8c;
            5'd17:   seg = 8'h89;
            5'd18:   seg = 8'hc2;
            5'd19:   seg = 8'ha1;
            5'd20:   seg = 8'hc6;
            5'd21:   seg = 8'hc1;
            5'd22:   seg = 8'hab;
            5'd23:   seg = 8'hcf;
            5'd24:   seg = 8'h83;
            5'd25:   seg = 8'h8e;
            5'd26:   seg = 8'hc8;
            5'd27:   seg = 8'h87;
            5'd28:   seg = 8'hcc;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/seven_segment_scan_driver.sv =====
`timescale 1ns / 1ps

// Five-position multiplexed seven-segment scan driver.
// Slave channel: s_tuser selects the beat kind (0 = scan tick, 1 = shadow
// write); a write beat loads one code into the shadow buffer and gives no
// result, a tick beat advances the refresh counter and the scan position and
// gives one master beat with active-low segments and position enable.
// Shadow codes reach the display on a tick when the incremented refresh
// counter exceeds the period held in the configuration register
// (cfg_wr_en / cfg_wr_data, write only, reset value 240).
// A tick enters the input register, is processed into the result register
// and is shown on the master side from then on. Throughput is one beat per
// cycle while m_tready holds, set by the input register and the result
// register each moving one beat a cycle.
// Reset (aresetn low, synchronous) clears both code buffers, the scan phase,
// the refresh counter and both stages, and restores the period.
// When the receiver stalls, the result holds; writes still flow, and one
// tick may wait in the input register before s_tready drops.

module seven_segment_scan_driver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] digit_index, [10:3] digit_code, rest zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] segments_n, [12:8] digit_enable_n,
                                   // [15:13] scan_position
);

    logic              in_valid_reg;
    ssd_pkg::op_t      in_op_reg;
    logic [2:0]        in_idx_reg;
    logic [7:0]        in_code_reg;
    logic              core_ready;
    ssd_pkg::in_beat_t in_beat;

    // Input stage takes a beat when empty or when the core drains it
    assign s_tready = !in_valid_reg || core_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= ssd_pkg::op_t'(s_tuser);
            in_idx_reg  <= s_tdata[2:0];
            in_code_reg <= s_tdata[10:3];
        end
    end

    assign in_beat.valid = in_valid_reg;
    assign in_beat.op    = in_op_reg;
    assign in_beat.idx   = in_idx_reg;
    assign in_beat.code  = in_code_reg;

    ssd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_beat     (in_beat),
        .in_ready    (core_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== rtl/ssd_decode.sv =====
`timescale 1ns / 1ps

module ssd_decode (
    input  logic [7:0] code,
    input  logic [2:0] pos,
    output logic [7:0] segments_n
);

    logic [7:0] glyph;

    // Look up the glyph and light the decimal point from code bit 7
    always_comb begin
        glyph = ssd_pkg::glyph_lookup(code[4:0]);
        if (code[7]) begin
            glyph[7] = 1'b0;
        end
    end

    // Fifth position shows a fixed pair of segments or nothing
    always_comb begin
        if (pos == ssd_pkg::POS_LAST) begin
            segments_n = (code == ssd_pkg::POS4_ON_CODE) ? ssd_pkg::SEG_POS4_ON
                                                         : ssd_pkg::SEG_BLANK;
        end else begin
            segments_n = glyph;
        end
    end

endmodule

// ===== rtl/ssd_core.sv =====
`timescale 1ns / 1ps

module ssd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  ssd_pkg::in_beat_t    in_beat,
    output logic                 in_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata
);

    logic [7:0]  shadow_reg [0:ssd_pkg::POS_NUM-1];
    logic [7:0]  shown_reg  [0:ssd_pkg::POS_NUM-1];
    logic [7:0]  shown_next [0:ssd_pkg::POS_NUM-1];
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] count_reg;
    logic [15:0] count_inc;
    logic [15:0] period_reg;
    logic        copy_now;
    logic        fire;
    logic        fire_tick;
    logic        fire_write;
    logic [7:0]  seg_next;
    logic        out_valid_reg;
    logic [7:0]  seg_reg;
    logic [4:0]  enable_reg;
    logic [2:0]  pos_reg;

    // Writes never wait; ticks wait for room in the result register
    assign in_ready   = (in_beat.op == ssd_pkg::OP_WRITE) || !out_valid_reg || m_tready;
    assign fire       = in_beat.valid && in_ready;
    assign fire_tick  = fire && (in_beat.op == ssd_pkg::OP_TICK);
    assign fire_write = fire && (in_beat.op == ssd_pkg::OP_WRITE);

    // Advance refresh counter and decide on a copy
    assign count_inc = count_reg + 16'd1;
    assign copy_now  = count_inc > period_reg;

    always_comb begin
        for (int i = 0; i < ssd_pkg::POS_NUM; i++) begin
            shown_next[i] = copy_now ? shadow_reg[i] : shown_reg[i];
        end
    end

    // Advance scan phase modulo five
    assign phase_next = (phase_reg == ssd_pkg::POS_LAST) ? ssd_pkg::POS_FIRST
                                                         : phase_reg + 3'd1;

    ssd_decode u_decode (
        .code       (shown_next[phase_next]),
        .pos        (phase_next),
        .segments_n (seg_next)
    );

    // Hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= ssd_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            period_reg <= cfg_wr_data;
        end
    end

    // Update shadow, shown buffer, counter and phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ssd_pkg::POS_NUM; i++) begin
                shadow_reg[i] <= 8'd0;
                shown_reg[i]  <= 8'd0;
            end
            phase_reg <= ssd_pkg::POS_FIRST;
            count_reg <= 16'd0;
        end else begin
            if (fire_write && (in_beat.idx <= ssd_pkg::POS_LAST)) begin
                shadow_reg[in_beat.idx] <= in_beat.code;
            end
            if (fire_tick) begin
                for (int i = 0; i < ssd_pkg::POS_NUM; i++) begin
                    shown_reg[i] <= shown_next[i];
                end
                phase_reg <= phase_next;
                count_reg <= copy_now ? 16'd0 : count_inc;
            end
        end
    end

    // Result register: load on a tick, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire_tick) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_tick) begin
            seg_reg    <= seg_next;
            enable_reg <= ~(5'b00001 << phase_next);
            pos_reg    <= phase_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pos_reg, enable_reg, seg_reg};

    // A write beat never produces a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_write && !out_valid_reg |=> !out_valid_reg)
        else $error("write beat produced a result");

    // A tick always shows the phase it moved to
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_tick |=> out_valid_reg && (pos_reg == $past(phase_next)))
        else $error("tick result missing or at wrong position");

    // Exactly one enable is active, and it matches the position
    a_enable_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $onehot(~enable_reg) && !enable_reg[pos_reg]
                          && (pos_reg <= ssd_pkg::POS_LAST))
        else $error("enable not one-hot at scan position");

    // An empty result register never blocks a tick
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> in_ready)
        else $error("core stalled with empty result register");

endmodule
